/* rtl/core/pso_pu_pkg.sv */
// Shared constants and types for the particle swarm update core.
// No dependencies; imported by the inertia unit and the top level.
package pso_pu_pkg;

  localparam int unsigned DataWidth   = 32;
  localparam int unsigned RandWidth   = 16;
  localparam int unsigned WeightWidth = 31;   // unsigned Q0.31 inertia weight
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned DivSteps    = 30;   // quotient bits of e*2^30/m

  // Q0.31 and Q16 constants
  localparam logic [WeightWidth-1:0] WNineTenths = 31'd1932735283;
  localparam logic [WeightWidth-1:0] HalfQ31     = 31'd1073741824;
  localparam logic [17:0]            GainQ16     = 18'd134349;   // 2.05
  localparam logic signed [15:0]     VlimQ16     = 16'sd13107;   // 0.2

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CfgEvalsDone  = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgEvalBudget = 1'b1;

  typedef struct packed {
    logic                   busy;
    logic [WeightWidth-1:0] weight;
  } inertia_t;

endpackage

/* rtl/core/pso_particle_update_core.sv */
// Particle swarm update core: one particle dimension per transaction.
// Uses pso_pu_pkg and pso_pu_inertia.
//
// Takes one transaction per clock while in_stall is low and passes each result
// through input register, multiply, sum, velocity clamp and position clamp.
// Four multipliers sit in parallel in the second stage; that stage and the
// three-way sum set the clock. A stall on the output freezes the whole
// pipeline and is passed straight back to in_stall. Writing either
// configuration register restarts the inertia computation; in_stall is then
// held high through the load state and the divider steps, or through the load
// state alone when evaluations_done >= evaluation_budget or the budget is zero.
// All data are signed Q16.16, random inputs unsigned Q0.16, and every right
// shift rounds toward minus infinity.
module pso_particle_update_core (
  input  logic                                      clk,
  input  logic                                      rst,
  // configuration
  input  logic                                      cfg_write,
  input  logic [pso_pu_pkg::CfgIdxWidth-1:0]        cfg_index,
  input  logic [pso_pu_pkg::DataWidth-1:0]          cfg_data,
  // input channel
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [pso_pu_pkg::DataWidth-1:0]   velocity_in,
  input  logic signed [pso_pu_pkg::DataWidth-1:0]   position_in,
  input  logic signed [pso_pu_pkg::DataWidth-1:0]   personal_best,
  input  logic signed [pso_pu_pkg::DataWidth-1:0]   swarm_best,
  input  logic [pso_pu_pkg::RandWidth-1:0]          rand_cognitive,
  input  logic [pso_pu_pkg::RandWidth-1:0]          rand_social,
  input  logic signed [pso_pu_pkg::DataWidth-1:0]   lower_bound,
  input  logic signed [pso_pu_pkg::DataWidth-1:0]   upper_bound,
  // output channel
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [pso_pu_pkg::DataWidth-1:0]   velocity_out,
  output logic signed [pso_pu_pkg::DataWidth-1:0]   position_out,
  output logic                                      velocity_limited,
  output logic                                      position_limited
);
  import pso_pu_pkg::*;

  inertia_t status;

  pso_pu_inertia u_inertia (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status)
  );

  // Global pipeline enable: everything moves unless the output holds a
  // result that is being stalled.
  logic advance;
  logic accept;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = status.busy || !advance;
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------- stage 1
  // Register inputs, form differences and the Q2.16 gains.
  logic                 s1_valid;
  logic signed [31:0]   s1_v, s1_x, s1_lo, s1_hi;
  logic signed [32:0]   s1_d1, s1_d2, s1_range;
  logic        [17:0]   s1_g1, s1_g2;
  logic        [33:0]   g1_prod, g2_prod;

  assign g1_prod = 34'(GainQ16) * 34'(rand_cognitive);
  assign g2_prod = 34'(GainQ16) * 34'(rand_social);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_v     <= velocity_in;
      s1_x     <= position_in;
      s1_lo    <= lower_bound;
      s1_hi    <= upper_bound;
      s1_d1    <= 33'(personal_best) - 33'(position_in);
      s1_d2    <= 33'(swarm_best) - 33'(position_in);
      s1_range <= 33'(upper_bound) - 33'(lower_bound);
      s1_g1    <= g1_prod[33:16];
      s1_g2    <= g2_prod[33:16];
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Inertia, cognitive and social terms, and the velocity limit.
  logic                 s2_valid;
  logic signed [31:0]   s2_t0, s2_vmax, s2_x, s2_lo, s2_hi;
  logic signed [35:0]   s2_t1, s2_t2;
  logic signed [63:0]   p0;
  logic signed [51:0]   p1, p2;
  logic signed [47:0]   pv;
  logic signed [31:0]   weight_s;
  logic signed [18:0]   g1_s, g2_s;

  assign weight_s = $signed({1'b0, status.weight});
  assign g1_s     = $signed({1'b0, s1_g1});
  assign g2_s     = $signed({1'b0, s1_g2});
  assign p0       = 64'(weight_s) * 64'(s1_v);
  assign p1       = 52'(s1_d1) * 52'(g1_s);
  assign p2       = 52'(s1_d2) * 52'(g2_s);
  assign pv       = 48'(s1_range) * 48'(VlimQ16);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_t0   <= p0[62:31];
      s2_t1   <= p1[51:16];
      s2_t2   <= p2[51:16];
      s2_vmax <= pv[47:16];
      s2_x    <= s1_x;
      s2_lo   <= s1_lo;
      s2_hi   <= s1_hi;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Exact sum of the three terms.
  logic                 s3_valid;
  logic signed [37:0]   s3_acc;
  logic signed [31:0]   s3_vmax, s3_x, s3_lo, s3_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_acc  <= 38'(s2_t0) + 38'(s2_t1) + 38'(s2_t2);
      s3_vmax <= s2_vmax;
      s3_x    <= s2_x;
      s3_lo   <= s2_lo;
      s3_hi   <= s2_hi;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Velocity clamp, upper test first; then advance the position.
  logic                 s4_valid;
  logic signed [31:0]   s4_vel, s4_lo, s4_hi;
  logic signed [32:0]   s4_xsum;
  logic                 s4_vlim;
  logic signed [37:0]   vel_c, vm_pos, vm_neg;
  logic                 vlim_c;
  logic signed [31:0]   vel_w;

  always_comb begin
    vm_pos = 38'(s3_vmax);
    vm_neg = -vm_pos;
    vel_c  = s3_acc;
    vlim_c = 1'b0;
    if (vel_c > vm_pos) begin
      vel_c  = vm_pos;
      vlim_c = 1'b1;
    end
    if (vel_c < vm_neg) begin
      vel_c  = vm_neg;
      vlim_c = 1'b1;
    end
    vel_w = vel_c[31:0];   // |vmax| < 2^30, so the clamped value fits
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (advance) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_vel  <= vel_w;
      s4_vlim <= vlim_c;
      s4_xsum <= 33'(s3_x) + 33'(vel_w);
      s4_lo   <= s3_lo;
      s4_hi   <= s3_hi;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Position clamp, lower test first so the upper bound wins when inverted.
  logic signed [32:0]   pos_c, lo_e, hi_e;
  logic                 plim_c;

  always_comb begin
    lo_e   = 33'(s4_lo);
    hi_e   = 33'(s4_hi);
    pos_c  = s4_xsum;
    plim_c = 1'b0;
    if (pos_c < lo_e) begin
      pos_c  = lo_e;
      plim_c = 1'b1;
    end
    if (pos_c > hi_e) begin
      pos_c  = hi_e;
      plim_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      velocity_out     <= s4_vel;
      position_out     <= pos_c[31:0];
      velocity_limited <= s4_vlim;
      position_limited <= plim_c;
    end
  end

endmodule

/* rtl/core/pso_pu_inertia.sv */
// Inertia weight unit: holds the evaluation registers and recomputes
// w = 0.9 - 0.5*e/m with a radix-2 restoring divider. Uses pso_pu_pkg.
module pso_pu_inertia (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pso_pu_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [pso_pu_pkg::DataWidth-1:0]    cfg_data,
  output pso_pu_pkg::inertia_t                status
);
  import pso_pu_pkg::*;

  localparam int unsigned CntWidth = $clog2(DivSteps);

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV} state_t;

  state_t                 state;
  logic [DataWidth-1:0]   evals;
  logic [DataWidth-1:0]   budget;
  logic [WeightWidth-1:0] weight;
  logic [DataWidth-1:0]   rem;
  logic [DataWidth-1:0]   rem_next;
  logic [DivSteps-1:0]    quo;
  logic [DivSteps-1:0]    quo_next;
  logic [CntWidth-1:0]    cnt;
  logic [DataWidth:0]     shifted;

  // one quotient bit per cycle while in ST_DIV; rem stays below budget
  always_comb begin
    shifted = {rem, 1'b0};
    if (shifted >= {1'b0, budget}) begin
      rem_next = DataWidth'(shifted - {1'b0, budget});
      quo_next = {quo[DivSteps-2:0], 1'b1};
    end else begin
      rem_next = shifted[DataWidth-1:0];
      quo_next = {quo[DivSteps-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      evals  <= '0;
      budget <= DataWidth'(1);
      weight <= WNineTenths;
    end else if (cfg_write) begin
      case (cfg_index)
        CfgEvalsDone:  evals  <= cfg_data;
        CfgEvalBudget: budget <= cfg_data;
        default: ;
      endcase
      state <= ST_LOAD;
    end else begin
      case (state)
        ST_LOAD: begin
          if (budget == '0 || evals >= budget) begin
            // saturated schedule: w = 0.4
            weight <= WNineTenths - HalfQ31;
            state  <= ST_IDLE;
          end else begin
            rem   <= evals;
            quo   <= '0;
            cnt   <= CntWidth'(DivSteps - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            weight <= WNineTenths - WeightWidth'(quo_next);
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign status.busy   = (state != ST_IDLE);
  assign status.weight = weight;

endmodule

/* rtl/core/pso_pu_checker.sv */
// Port-level checks for the particle swarm update core, bound to the top.
// Uses pso_pu_pkg for port widths.
module pso_pu_checker (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_write,
  input  logic                                      in_stall,
  input  logic                                      out_valid,
  input  logic                                      out_stall,
  input  logic signed [pso_pu_pkg::DataWidth-1:0]   velocity_out,
  input  logic signed [pso_pu_pkg::DataWidth-1:0]   position_out
);

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(velocity_out) &&
                                  $stable(position_out)))
    else $error("stalled result changed");

  // a stalled result at the output must push back on the input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while pipeline frozen");

  // new configuration blocks input while the weight is recomputed
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> in_stall)
    else $error("input taken during weight update");

endmodule

bind pso_particle_update_core pso_pu_checker u_pso_pu_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_write    (cfg_write),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .velocity_out (velocity_out),
  .position_out (position_out)
);
